// File: rtl/core/assert_macros.svh
// assertion macros shared by the rtl of the column color run scanner
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, off while reset is asserted
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// clocked check that also holds during reset
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// File: rtl/core/ccrs_pkg.sv
// types and constants of the column color run scanner
// no dependencies
package ccrs_pkg;

  // fixed field widths
  localparam int unsigned CLASS_W = 8;
  localparam int unsigned FIELD_COORD_W = 10;
  localparam int unsigned STEP_W = 4;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 8;

  // default coordinate width and reset values
  localparam int unsigned COORD_BITS = 10;
  localparam logic [7:0] RUN_THR_RST = 8'd10;
  localparam logic [7:0] FIELD_THR_RST = 8'd2;
  localparam logic [3:0] ROW_STEP_RST = 4'd3;

  // result queue depth
  localparam int unsigned FIFO_DEPTH = 4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_COLOR = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BALL_COLOR = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FIELD_COLOR_A = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FIELD_COLOR_B = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RUN_THRESHOLD = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FIELD_THRESHOLD = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_STEP = 3'd6;

  // result kinds
  localparam logic KIND_BALL = 1'b0;
  localparam logic KIND_LINE = 1'b1;

  typedef struct packed {
    logic [CLASS_W-1:0]       pixel_class;
    logic [FIELD_COORD_W-1:0] column;
    logic [FIELD_COORD_W-1:0] row;
    logic                     column_end;
  } pix_in_t;

  typedef struct packed {
    logic                     result_kind;
    logic [FIELD_COORD_W-1:0] out_column;
    logic [FIELD_COORD_W-1:0] out_row;
    logic                     found;
    logic                     last;
  } res_out_t;

endpackage

// File: rtl/core/column_color_run_scanner_top.sv
// top level of the column color run scanner: scan logic and result queue
// depends on ccrs_pkg and assert_macros.svh
//
// Usage:
// - input channel in_valid_i/in_ready_o/in_data_i carries one sampled pixel per
//   request, bottom to top within a column, column_end set on its last sample
// - output channel out_valid_o/out_ready_i/out_data_o carries results: a ball
//   candidate (first ball pixel after enough field pixels) and, on column end,
//   the line result; last marks the final result of one request
// - configuration is written through cfg_we_i/cfg_idx_i/cfg_data_i, only while
//   no request is in flight
// - a result is written into the registered result queue when its request is accepted
// - throughput: one request per cycle while in_ready_o is high; a request with two results
//   occupies the output port for both of them, and the four-entry result queue absorbs this
// - in_ready_o drops when the result queue has fewer than two free entries,
//   so a stalled receiver holds off new requests without losing results
// - reset clears the scan state and the queue and loads register defaults;
//   no clearing pass is needed
`include "assert_macros.svh"

module column_color_run_scanner_top #(
  parameter int unsigned CoordBits = ccrs_pkg::COORD_BITS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [ccrs_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [ccrs_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  ccrs_pkg::pix_in_t                   in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output ccrs_pkg::res_out_t                  out_data_o
);
  import ccrs_pkg::*;

  localparam int unsigned PtrW = $clog2(FIFO_DEPTH);
  localparam int unsigned CntW = PtrW + 1;
  localparam int unsigned SumW = CoordBits + 13;
  localparam logic [CoordBits-1:0] CoordMax = {CoordBits{1'b1}};

  // configuration registers
  logic [7:0] target_color_q, ball_color_q, field_color_a_q, field_color_b_q;
  logic [7:0] run_thr_q, field_thr_q;
  logic [STEP_W-1:0] row_step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_color_q  <= '0;
      ball_color_q    <= '0;
      field_color_a_q <= '0;
      field_color_b_q <= '0;
      run_thr_q       <= RUN_THR_RST;
      field_thr_q     <= FIELD_THR_RST;
      row_step_q      <= ROW_STEP_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_TARGET_COLOR:    target_color_q  <= cfg_data_i;
        REG_BALL_COLOR:      ball_color_q    <= cfg_data_i;
        REG_FIELD_COLOR_A:   field_color_a_q <= cfg_data_i;
        REG_FIELD_COLOR_B:   field_color_b_q <= cfg_data_i;
        REG_RUN_THRESHOLD:   run_thr_q       <= cfg_data_i;
        REG_FIELD_THRESHOLD: field_thr_q     <= cfg_data_i;
        REG_ROW_STEP:        row_step_q      <= cfg_data_i[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // scan state
  logic [7:0] run_count_q, run_count_d;
  logic [7:0] field_count_q, field_count_d;
  logic line_found_q, line_found_d;
  logic [CoordBits-1:0] line_row_q, line_row_d;
  logic ball_found_q, ball_found_d;

  // result queue
  res_out_t fifo_q [FIFO_DEPTH];
  logic [PtrW-1:0] rd_ptr_q, wr_ptr_q;
  logic [CntW-1:0] count_q, count_d;

  logic in_fire, out_fire;
  assign in_ready_o = (count_q <= CntW'(FIFO_DEPTH - 2));
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_valid_o = (count_q != '0);
  assign out_fire   = out_valid_o && out_ready_i;
  assign out_data_o = fifo_q[rd_ptr_q];

  // per-request scan logic
  logic [CoordBits-1:0] col_m, row_m;
  logic [7:0] thr;
  logic [7:0] fc_inc, rc_inc;
  logic is_field, ball_hit, col_end;
  logic [11:0] offs;
  logic [SumW-1:0] row_sum, row_val;
  logic [CoordBits-1:0] row_clamped;
  res_out_t res_ball, res_line, res0, res1;
  logic [1:0] push_n;

  assign col_m   = CoordBits'(in_data_i.column);
  assign row_m   = CoordBits'(in_data_i.row);
  assign col_end = in_data_i.column_end;
  assign thr     = (run_thr_q == '0) ? 8'd1 : run_thr_q;
  assign offs    = thr * row_step_q;

  // line row: row + thr * step - 1, clamped to the coordinate range
  always_comb begin
    row_sum = SumW'(row_m) + SumW'(offs);
    row_val = (row_sum == '0) ? '0 : row_sum - SumW'(1);
    row_clamped = (row_val > SumW'(CoordMax)) ? CoordMax : row_val[CoordBits-1:0];
  end

  // ball search, then run search, then column end
  always_comb begin
    field_count_d = field_count_q;
    ball_found_d  = ball_found_q;
    run_count_d   = run_count_q;
    line_found_d  = line_found_q;
    line_row_d    = line_row_q;
    ball_hit      = 1'b0;
    is_field      = (in_data_i.pixel_class == field_color_a_q) ||
                    (in_data_i.pixel_class == field_color_b_q);
    fc_inc        = (field_count_q == 8'hFF) ? field_count_q : field_count_q + 8'd1;
    rc_inc        = (run_count_q == 8'hFF) ? run_count_q : run_count_q + 8'd1;

    if (!ball_found_q) begin
      if (is_field) begin
        field_count_d = fc_inc;
      end
      if (in_data_i.pixel_class == ball_color_q && field_count_d >= field_thr_q) begin
        ball_hit     = 1'b1;
        ball_found_d = 1'b1;
      end
    end

    if (!line_found_q) begin
      if (in_data_i.pixel_class == target_color_q) begin
        run_count_d = rc_inc;
        if (rc_inc >= thr) begin
          line_row_d   = row_clamped;
          line_found_d = 1'b1;
        end
      end else begin
        run_count_d = '0;
      end
    end

    res_ball.result_kind = KIND_BALL;
    res_ball.out_column  = FIELD_COORD_W'(col_m);
    res_ball.out_row     = FIELD_COORD_W'(row_m);
    res_ball.found       = 1'b0;
    res_ball.last        = !col_end;

    res_line.result_kind = KIND_LINE;
    res_line.out_column  = FIELD_COORD_W'(col_m);
    res_line.out_row     = line_found_d ? FIELD_COORD_W'(line_row_d) : '0;
    res_line.found       = line_found_d;
    res_line.last        = 1'b1;

    res0 = ball_hit ? res_ball : res_line;
    res1 = res_line;
    push_n = {1'b0, ball_hit} + {1'b0, col_end};

    if (col_end) begin
      run_count_d   = '0;
      field_count_d = '0;
      line_found_d  = 1'b0;
      line_row_d    = '0;
      ball_found_d  = 1'b0;
    end
  end

  // state update on each accepted request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_count_q   <= '0;
      field_count_q <= '0;
      line_found_q  <= 1'b0;
      line_row_q    <= '0;
      ball_found_q  <= 1'b0;
    end else if (in_fire) begin
      run_count_q   <= run_count_d;
      field_count_q <= field_count_d;
      line_found_q  <= line_found_d;
      line_row_q    <= line_row_d;
      ball_found_q  <= ball_found_d;
    end
  end

  // queue occupancy
  always_comb begin
    count_d = count_q;
    if (in_fire) begin
      count_d = count_d + CntW'(push_n);
    end
    if (out_fire) begin
      count_d = count_d - CntW'(1);
    end
  end

  // queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= '0;
      wr_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (out_fire) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      if (in_fire) begin
        wr_ptr_q <= wr_ptr_q + PtrW'(push_n);
      end
    end
  end

  // queue payload writes, up to two entries per request
  always_ff @(posedge clk_i) begin
    if (in_fire && push_n != 2'd0) begin
      fifo_q[wr_ptr_q] <= res0;
    end
    if (in_fire && push_n == 2'd2) begin
      fifo_q[wr_ptr_q + PtrW'(1)] <= res1;
    end
  end

  // checks
  `ASSERT_ALWAYS(a_count_bound, !rst_ni || count_q <= CntW'(FIFO_DEPTH), "result queue overflow")
  `ASSERT_CLK(a_col_end_clears, in_fire && col_end |=> !line_found_q && !ball_found_q && run_count_q == '0 && field_count_q == '0, "state not cleared at column end")
  `ASSERT_CLK(a_line_holds, line_found_q && !(in_fire && col_end) |=> line_found_q && $stable(line_row_q), "line row changed after being found")
  `ASSERT_CLK(a_field_frozen, ball_found_q && !(in_fire && col_end) |=> $stable(field_count_q) && ball_found_q, "field count moved after ball found")
  `ASSERT_CLK(a_two_results_room, in_fire && push_n == 2'd2 |-> count_q <= CntW'(FIFO_DEPTH - 2), "no room for two results")

endmodule

// File: tb/tb_column_color_run_scanner_top.sv
// self-checking testbench for column_color_run_scanner_top: directed rows, then random columns
// depends on ccrs_pkg and the scanner rtl; predicts each result or takes a typed one, and compares field by field
module tb_column_color_run_scanner_top;
  import ccrs_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned ITEMS_PER_MODE = 630;
  localparam int unsigned SAT_RUN_LEN = 260;
  localparam int CoordMax = (1 << COORD_BITS) - 1;

  typedef struct packed {
    logic [7:0] target;
    logic [7:0] ball;
    logic [7:0] field_a;
    logic [7:0] field_b;
    logic [7:0] run_thr;
    logic [7:0] field_thr;
    logic [3:0] row_step;
  } scan_cfg_t;

  // one row of the directed part: a register write or a request
  typedef struct {
    bit                   is_reg;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [7:0]           reg_data;
    pix_in_t              px;
    int                   n_typed;
    res_out_t             r0;
    res_out_t             r1;
  } stim_row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [7:0]           cfg_data_i;
  logic                 in_valid_i;
  logic                 in_ready_o;
  pix_in_t              in_data_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  res_out_t             out_data_o;

  // typed expectation travelling with the request on the bus, -1 means predicted
  int                   typed_n;
  res_out_t             typed_r0;
  res_out_t             typed_r1;

  int unsigned          send_idle_pct;
  int unsigned          recv_idle_pct;
  int unsigned          items_sent = 0;
  int unsigned          error_count = 0;
  int unsigned          cycle_count = 0;

  // predictor copy of configuration and scan state
  scan_cfg_t            scan_cfg;
  logic [7:0]           run_len = '0;
  logic [7:0]           field_seen = '0;
  bit                   line_hit = 1'b0;
  logic [9:0]           line_row_q = '0;
  bit                   ball_hit = 1'b0;

  res_out_t             pending_results[$];
  stim_row_t            directed_rows[$];

  column_color_run_scanner_top i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic res_out_t mk_res(logic kind, logic [9:0] col, logic [9:0] row, logic hit,
                                      logic fin);
    res_out_t r;
    r.result_kind = kind;
    r.out_column  = col;
    r.out_row     = row;
    r.found       = hit;
    r.last        = fin;
    return r;
  endfunction

  // ball search, then run search, then column end; returns the number of results
  function automatic int scan_pixel(input pix_in_t px, output res_out_t first_res,
                                    output res_out_t second_res);
    res_out_t res [2];
    int n;
    int thr;
    int v;
    n = 0;
    res[0] = '0;
    res[1] = '0;
    if (!ball_hit) begin
      if (px.pixel_class == scan_cfg.field_a || px.pixel_class == scan_cfg.field_b) begin
        if (field_seen != 8'hFF) field_seen++;
      end
      if (px.pixel_class == scan_cfg.ball && field_seen >= scan_cfg.field_thr) begin
        res[n] = mk_res(KIND_BALL, px.column, px.row, 1'b0, 1'b0);
        n++;
        ball_hit = 1'b1;
      end
    end
    if (!line_hit) begin
      if (px.pixel_class == scan_cfg.target) begin
        thr = (scan_cfg.run_thr == 8'd0) ? 1 : int'(scan_cfg.run_thr);
        if (run_len != 8'hFF) run_len++;
        if (int'(run_len) >= thr) begin
          v = int'(px.row) + thr * int'(scan_cfg.row_step) - 1;
          if (v < 0) v = 0;
          if (v > CoordMax) v = CoordMax;
          line_row_q = 10'(v);
          line_hit = 1'b1;
        end
      end else begin
        run_len = '0;
      end
    end
    if (px.column_end) begin
      res[n] = mk_res(KIND_LINE, px.column, line_hit ? line_row_q : 10'd0, line_hit, 1'b0);
      n++;
      run_len = '0;
      field_seen = '0;
      line_hit = 1'b0;
      line_row_q = '0;
      ball_hit = 1'b0;
    end
    if (n > 0) res[n-1].last = 1'b1;
    first_res = res[0];
    second_res = res[1];
    return n;
  endfunction

  // accepted requests feed the predictor, accepted results are checked in order
  always @(posedge clk_i) begin : scoreboard
    res_out_t r0;
    res_out_t r1;
    res_out_t want;
    int n;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        n = scan_pixel(in_data_i, r0, r1);
        if (typed_n >= 0) begin
          n = typed_n;
          r0 = typed_r0;
          r1 = typed_r1;
        end
        if (n > 0) pending_results.insert(pending_results.size(), r0);
        if (n > 1) pending_results.insert(pending_results.size(), r1);
      end
      if (out_valid_o && out_ready_i) begin
        if (pending_results.size() == 0) begin
          $error("result_kind %0d column %0d row %0d with no result expected",
                 out_data_o.result_kind, out_data_o.out_column, out_data_o.out_row);
          error_count++;
        end else begin
          want = pending_results.pop_front();
          if (out_data_o.result_kind !== want.result_kind) begin
            $error("result_kind: expected %0d, got %0d", want.result_kind,
                   out_data_o.result_kind);
            error_count++;
          end
          if (out_data_o.out_column !== want.out_column) begin
            $error("out_column: expected %0d, got %0d", want.out_column, out_data_o.out_column);
            error_count++;
          end
          if (out_data_o.out_row !== want.out_row) begin
            $error("out_row: expected %0d, got %0d", want.out_row, out_data_o.out_row);
            error_count++;
          end
          if (out_data_o.found !== want.found) begin
            $error("found: expected %0d, got %0d", want.found, out_data_o.found);
            error_count++;
          end
          if (out_data_o.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, out_data_o.last);
            error_count++;
          end
        end
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // receiver stalls
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // one request, with random sender gaps ahead of it
  task automatic send_pixel(input pix_in_t px, input int n_typed, input res_out_t r0,
                            input res_out_t r1);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= px;
    typed_n    <= n_typed;
    typed_r0   <= r0;
    typed_r1   <= r1;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
  endtask

  // drain all results, then allow for a request still in flight with no result
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    case (idx)
      REG_TARGET_COLOR:    scan_cfg.target = data;
      REG_BALL_COLOR:      scan_cfg.ball = data;
      REG_FIELD_COLOR_A:   scan_cfg.field_a = data;
      REG_FIELD_COLOR_B:   scan_cfg.field_b = data;
      REG_RUN_THRESHOLD:   scan_cfg.run_thr = data;
      REG_FIELD_THRESHOLD: scan_cfg.field_thr = data;
      REG_ROW_STEP:        scan_cfg.row_step = data[3:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_config(input scan_cfg_t c);
    logic [7:0] step_data;
    step_data = 8'($urandom_range(0, 255));
    step_data[3:0] = c.row_step;
    wait_idle();
    write_reg(REG_TARGET_COLOR, c.target);
    write_reg(REG_BALL_COLOR, c.ball);
    write_reg(REG_FIELD_COLOR_A, c.field_a);
    write_reg(REG_FIELD_COLOR_B, c.field_b);
    write_reg(REG_RUN_THRESHOLD, c.run_thr);
    write_reg(REG_FIELD_THRESHOLD, c.field_thr);
    write_reg(REG_ROW_STEP, step_data);
  endtask

  function automatic void add_pix(logic [7:0] cls, logic [9:0] col, logic [9:0] row,
                                  bit col_end, int n, res_out_t r0, res_out_t r1);
    stim_row_t r;
    r.is_reg = 1'b0;
    r.reg_idx = '0;
    r.reg_data = '0;
    r.px.pixel_class = cls;
    r.px.column = col;
    r.px.row = row;
    r.px.column_end = col_end;
    r.n_typed = n;
    r.r0 = r0;
    r.r1 = r1;
    directed_rows.insert(directed_rows.size(), r);
  endfunction

  function automatic void add_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] data);
    stim_row_t r;
    r.is_reg = 1'b1;
    r.reg_idx = idx;
    r.reg_data = data;
    r.px = '0;
    r.n_typed = -1;
    r.r0 = '0;
    r.r1 = '0;
    directed_rows.insert(directed_rows.size(), r);
  endfunction

  // well-formed column: sticky classes, mostly from the configured set, so runs form, bottom to top
  task automatic scan_column();
    pix_in_t px;
    int unsigned len;
    int unsigned k;
    logic [7:0] cls;
    len = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 24) : $urandom_range(25, 60);
    px.column = 10'($urandom_range(0, 1023));
    px.row = 10'($urandom_range(0, 1023));
    cls = scan_cfg.target;
    for (k = 0; k < len; k++) begin
      if ($urandom_range(0, 99) >= 45) begin
        case ($urandom_range(0, 9))
          0, 1, 2: cls = scan_cfg.target;
          3, 4:    cls = scan_cfg.field_a;
          5, 6:    cls = scan_cfg.field_b;
          7:       cls = scan_cfg.ball;
          default: cls = 8'($urandom_range(0, 255));
        endcase
      end
      px.pixel_class = cls;
      px.column_end = (k == len - 1);
      send_pixel(px, -1, '0, '0);
      px.row = px.row - scan_cfg.row_step;
    end
  endtask

  // long column: maximum thresholds, field count driven past saturation before the ball
  task automatic saturate_column();
    scan_cfg_t c;
    pix_in_t px;
    int unsigned k;
    c.target = 8'($urandom_range(0, 255));
    c.field_a = c.target;
    c.field_b = c.target ^ 8'h01;
    c.ball = c.target ^ 8'h80;
    c.run_thr = 8'd255;
    c.field_thr = 8'd255;
    c.row_step = 4'($urandom_range(1, 15));
    set_config(c);
    px.column = 10'($urandom_range(0, 1023));
    px.row = 10'd1023;
    px.column_end = 1'b0;
    px.pixel_class = c.target;
    for (k = 0; k < SAT_RUN_LEN; k++) begin
      send_pixel(px, -1, '0, '0);
      px.row = px.row - c.row_step;
    end
    px.pixel_class = c.ball;
    send_pixel(px, -1, '0, '0);
    px.pixel_class = c.field_b;
    px.column_end = 1'b1;
    send_pixel(px, -1, '0, '0);
  endtask

  initial begin
    scan_cfg_t cfg;
    pix_in_t px;
    int unsigned mode;
    int unsigned mode_start;
    int unsigned roll;
    int unsigned i;

    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    out_ready_i = 1'b0;
    typed_n = -1;
    typed_r0 = '0;
    typed_r1 = '0;
    send_idle_pct = 20;
    recv_idle_pct = 50;
    scan_cfg.target = '0;
    scan_cfg.ball = '0;
    scan_cfg.field_a = '0;
    scan_cfg.field_b = '0;
    scan_cfg.run_thr = RUN_THR_RST;
    scan_cfg.field_thr = FIELD_THR_RST;
    scan_cfg.row_step = ROW_STEP_RST;

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: every class is 0, so class 0 is field, ball and target at once
    add_pix(8'h55, 0, 0, 1'b1, 1, mk_res(KIND_LINE, 0, 0, 1'b0, 1'b1), '0);
    add_pix(8'h00, 1023, 1023, 1'b0, 0, '0, '0);
    add_pix(8'h00, 1023, 1023, 1'b0, 1, mk_res(KIND_BALL, 1023, 1023, 1'b0, 1'b1), '0);
    add_pix(8'hFF, 1023, 1023, 1'b1, 1, mk_res(KIND_LINE, 1023, 0, 1'b0, 1'b1), '0);
    // single-sample run at the top row, line row clamped high
    add_reg(REG_TARGET_COLOR, 8'h11);
    add_reg(REG_BALL_COLOR, 8'h22);
    add_reg(REG_FIELD_COLOR_A, 8'h33);
    add_reg(REG_FIELD_COLOR_B, 8'h44);
    add_reg(REG_RUN_THRESHOLD, 8'd1);
    add_reg(REG_FIELD_THRESHOLD, 8'd0);
    add_reg(REG_ROW_STEP, 8'd15);
    add_pix(8'h11, 5, 1023, 1'b1, 1, mk_res(KIND_LINE, 5, 1023, 1'b1, 1'b1), '0);
    // zero threshold acts as one, zero step clamps the line row at 0
    add_reg(REG_RUN_THRESHOLD, 8'd0);
    add_reg(REG_ROW_STEP, 8'd0);
    add_pix(8'h11, 6, 0, 1'b1, 1, mk_res(KIND_LINE, 6, 0, 1'b1, 1'b1), '0);
    // ball and line from the same sample, ball first
    add_reg(REG_BALL_COLOR, 8'h11);
    add_reg(REG_RUN_THRESHOLD, 8'd1);
    add_reg(REG_ROW_STEP, 8'd4);
    add_pix(8'h11, 7, 100, 1'b1, 2, mk_res(KIND_BALL, 7, 100, 1'b0, 1'b0),
            mk_res(KIND_LINE, 7, 103, 1'b1, 1'b1));
    // interleaved field, ball and target samples; run broken, then found and frozen
    add_reg(REG_BALL_COLOR, 8'h22);
    add_reg(REG_RUN_THRESHOLD, 8'd3);
    add_reg(REG_FIELD_THRESHOLD, 8'd2);
    add_reg(REG_ROW_STEP, 8'd2);
    add_pix(8'h33, 8, 10, 1'b0, -1, '0, '0);
    add_pix(8'h11, 8, 12, 1'b0, -1, '0, '0);
    add_pix(8'h22, 8, 14, 1'b0, -1, '0, '0);
    add_pix(8'h44, 8, 16, 1'b0, -1, '0, '0);
    add_pix(8'h11, 8, 18, 1'b0, -1, '0, '0);
    add_pix(8'h11, 8, 20, 1'b0, -1, '0, '0);
    add_pix(8'h22, 8, 22, 1'b0, -1, '0, '0);
    add_pix(8'h11, 8, 24, 1'b0, -1, '0, '0);
    add_pix(8'h11, 8, 26, 1'b0, -1, '0, '0);
    add_pix(8'h11, 8, 28, 1'b0, -1, '0, '0);
    add_pix(8'h11, 8, 30, 1'b0, -1, '0, '0);
    add_pix(8'h22, 8, 32, 1'b1, -1, '0, '0);
    add_pix(8'hAA, 1023, 512, 1'b1, -1, '0, '0);

    for (i = 0; i < directed_rows.size(); i++) begin
      if (directed_rows[i].is_reg) begin
        wait_idle();
        write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_data);
      end else begin
        send_pixel(directed_rows[i].px, directed_rows[i].n_typed, directed_rows[i].r0,
                   directed_rows[i].r1);
      end
    end

    // random part under three stall patterns
    for (mode = 0; mode < 3; mode++) begin
      wait_idle();
      case (mode)
        0: begin
          send_idle_pct = 20;
          recv_idle_pct = 50;
        end
        1: begin
          send_idle_pct = 50;
          recv_idle_pct = 20;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      mode_start = items_sent;
      saturate_column();
      while (items_sent - mode_start < ITEMS_PER_MODE) begin
        roll = $urandom_range(0, 99);
        if (roll < 12) begin
          // new settings, with colliding classes and extreme thresholds now and then
          cfg.target = 8'($urandom_range(0, 255));
          cfg.ball = ($urandom_range(0, 99) < 15) ? cfg.target : 8'($urandom_range(0, 255));
          cfg.field_a = ($urandom_range(0, 99) < 10) ? cfg.target : 8'($urandom_range(0, 255));
          cfg.field_b = ($urandom_range(0, 99) < 20) ? cfg.field_a : 8'($urandom_range(0, 255));
          roll = $urandom_range(0, 99);
          cfg.run_thr = (roll < 10) ? 8'd0 : (roll < 15) ? 8'd255 : 8'($urandom_range(1, 6));
          roll = $urandom_range(0, 99);
          cfg.field_thr = (roll < 10) ? 8'd0 : (roll < 15) ? 8'd255 : 8'($urandom_range(1, 4));
          cfg.row_step = 4'($urandom_range(0, 15));
          set_config(cfg);
        end else if (roll < 18) begin
          // noise: unrelated samples, column end anywhere
          repeat ($urandom_range(1, 4)) begin
            px.pixel_class = 8'($urandom_range(0, 255));
            px.column = 10'($urandom_range(0, 1023));
            px.row = 10'($urandom_range(0, 1023));
            px.column_end = 1'($urandom_range(0, 1));
            send_pixel(px, -1, '0, '0);
          end
        end else begin
          scan_column();
        end
      end
    end

    // drain and let the pipeline settle
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
